// File: rtl/kto_pkg.sv
// Shared types and constants for the keyed table with oldest-entry replacement.
`timescale 1ns / 1ps
package kto_pkg;

    localparam int KEY_W   = 64;
    localparam int TIME_W  = 32;
    localparam int DATA_W  = 64;
    localparam int COUNT_W = 5;

    localparam int unsigned COUNT_MAX = 31;

    localparam logic [TIME_W-1:0] AGE_INVALID = '1;

    localparam int S_TDATA_W = 2 * KEY_W + TIME_W + DATA_W;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = ((TIME_W + DATA_W + COUNT_W + 7) / 8) * 8;
    localparam int M_TUSER_W = 1;

    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // Running search result handed from cell to cell
    typedef struct packed {
        logic              hit;
        logic [TIME_W-1:0] hit_time;
        logic              best_vld;
        logic [TIME_W-1:0] best_age;
    } kto_scan_t;

endpackage

// File: rtl/kto_cell.sv
// One table entry with its stage of the key-match and oldest-entry search.
`timescale 1ns / 1ps
module kto_cell #(
    parameter int INDEX        = 0,
    parameter int IDX_W        = 5,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [kto_pkg::KEY_W-1:0]  key_hi,
    input  logic [kto_pkg::KEY_W-1:0]  key_lo,
    input  logic [kto_pkg::TIME_W-1:0] now_ms,
    input  logic                      wr_en,
    input  logic [IDX_W-1:0]          wr_idx,
    input  logic [PAYLOAD_BITS-1:0]   wr_payload,
    input  logic                      go_in,
    input  kto_pkg::kto_scan_t        scan_in,
    input  logic [IDX_W-1:0]          hit_idx_in,
    input  logic [IDX_W-1:0]          best_idx_in,
    input  logic [PAYLOAD_BITS-1:0]   hit_data_in,
    output logic                      go_out,
    output kto_pkg::kto_scan_t        scan_out,
    output logic [IDX_W-1:0]          hit_idx_out,
    output logic [IDX_W-1:0]          best_idx_out,
    output logic [PAYLOAD_BITS-1:0]   hit_data_out
);
    import kto_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic                    valid_reg;
    logic [KEY_W-1:0]        key_hi_reg;
    logic [KEY_W-1:0]        key_lo_reg;
    logic [TIME_W-1:0]       time_reg;
    logic [PAYLOAD_BITS-1:0] data_reg;

    logic                    go_reg;
    kto_scan_t               scan_reg,     scan_next;
    logic [IDX_W-1:0]        hit_idx_reg,  hit_idx_next;
    logic [IDX_W-1:0]        best_idx_reg, best_idx_next;
    logic [PAYLOAD_BITS-1:0] hit_data_reg, hit_data_next;

    logic              match;
    logic [TIME_W-1:0] age;
    logic              wr_sel;

    assign match  = valid_reg && (key_hi_reg == key_hi) && (key_lo_reg == key_lo);
    assign age    = valid_reg ? (now_ms - time_reg) : AGE_INVALID;
    assign wr_sel = wr_en && (wr_idx == MY_IDX);

    always_comb begin
        scan_next     = scan_in;
        hit_idx_next  = hit_idx_in;
        best_idx_next = best_idx_in;
        hit_data_next = hit_data_in;
        // lowest-index match wins
        if (!scan_in.hit && match) begin
            scan_next.hit      = 1'b1;
            scan_next.hit_time = time_reg;
            hit_idx_next       = MY_IDX;
            hit_data_next      = data_reg;
        end
        // ties go to the later entry
        if (age >= scan_in.best_age) begin
            scan_next.best_age = age;
            scan_next.best_vld = valid_reg;
            best_idx_next      = MY_IDX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            go_reg    <= 1'b0;
        end else begin
            go_reg <= go_in;
            if (wr_sel) begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_sel) begin
            key_hi_reg <= key_hi;
            key_lo_reg <= key_lo;
            time_reg   <= now_ms;
            data_reg   <= wr_payload;
        end
        scan_reg     <= scan_next;
        hit_idx_reg  <= hit_idx_next;
        best_idx_reg <= best_idx_next;
        hit_data_reg <= hit_data_next;
    end

    assign go_out       = go_reg;
    assign scan_out     = scan_reg;
    assign hit_idx_out  = hit_idx_reg;
    assign best_idx_out = best_idx_reg;
    assign hit_data_out = hit_data_reg;

endmodule

// File: rtl/keyed_table_oldest_replace.sv
// Top level: fully associative keyed table with oldest-entry replacement.
// The command is registered; the search token then walks the row of entry
// cells one cell per cycle, and the entry is written as the token leaves.
// A new command is taken only once the result has gone to the output.
// Reset: synchronous, active low; clears all entry valid flags and the count.
// The table is usable in the cycle after reset is released.
`timescale 1ns / 1ps
module keyed_table_oldest_replace #(
    parameter int ENTRIES      = 24,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // key_hi, key_lo, heard_ms, payload
    input  logic [kto_pkg::S_TDATA_W-1:0]  s_tdata,
    // command
    input  logic [kto_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // found_heard_ms, found_payload, used_count, zero pad
    output logic [kto_pkg::M_TDATA_W-1:0]  m_tdata,
    // found
    output logic [kto_pkg::M_TUSER_W-1:0]  m_tuser
);
    import kto_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CW    = CNT_W + COUNT_W;
    localparam int PAD_W = M_TDATA_W - (TIME_W + DATA_W + COUNT_W);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_HOLD = 3'b100
    } kto_state_t;

    kto_state_t              state_reg, state_next;
    logic                    start_reg;
    logic                    cmd_reg;
    logic [KEY_W-1:0]        key_hi_reg;
    logic [KEY_W-1:0]        key_lo_reg;
    logic [TIME_W-1:0]       now_reg;
    logic [PAYLOAD_BITS-1:0] payload_reg;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;

    logic                    res_found_reg;
    logic [TIME_W-1:0]       res_time_reg;
    logic [DATA_W-1:0]       res_data_reg;

    logic                    m_valid_reg, m_valid_next;
    logic                    m_found_reg;
    logic [TIME_W-1:0]       m_time_reg;
    logic [DATA_W-1:0]       m_data_reg;
    logic [COUNT_W-1:0]      m_count_reg;

    logic                    go_chain       [ENTRIES+1];
    kto_scan_t               scan_chain     [ENTRIES+1];
    logic [IDX_W-1:0]        hit_idx_chain  [ENTRIES+1];
    logic [IDX_W-1:0]        best_idx_chain [ENTRIES+1];
    logic [PAYLOAD_BITS-1:0] hit_data_chain [ENTRIES+1];

    logic                    s_xfer;
    logic                    scan_done;
    logic                    out_free;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_idx;
    logic                    lookup_hit;
    logic [CW-1:0]           cnt_wide;
    logic [COUNT_W-1:0]      cnt_sat;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_xfer    = s_tvalid && s_tready;
    assign scan_done = (state_reg == ST_SCAN) && go_chain[ENTRIES];
    assign out_free  = !m_valid_reg || m_tready;

    assign go_chain[0]       = start_reg;
    assign scan_chain[0]     = '{hit: 1'b0, hit_time: '0, best_vld: 1'b0, best_age: '0};
    assign hit_idx_chain[0]  = '0;
    assign best_idx_chain[0] = '0;
    assign hit_data_chain[0] = '0;

    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        kto_cell #(
            .INDEX       (i),
            .IDX_W       (IDX_W),
            .PAYLOAD_BITS(PAYLOAD_BITS)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .key_hi      (key_hi_reg),
            .key_lo      (key_lo_reg),
            .now_ms      (now_reg),
            .wr_en       (wr_en),
            .wr_idx      (wr_idx),
            .wr_payload  (payload_reg),
            .go_in       (go_chain[i]),
            .scan_in     (scan_chain[i]),
            .hit_idx_in  (hit_idx_chain[i]),
            .best_idx_in (best_idx_chain[i]),
            .hit_data_in (hit_data_chain[i]),
            .go_out      (go_chain[i+1]),
            .scan_out    (scan_chain[i+1]),
            .hit_idx_out (hit_idx_chain[i+1]),
            .best_idx_out(best_idx_chain[i+1]),
            .hit_data_out(hit_data_chain[i+1])
        );
    end

    assign wr_en      = scan_done && (cmd_reg == CMD_RECORD);
    assign wr_idx     = scan_chain[ENTRIES].hit ? hit_idx_chain[ENTRIES]
                                                : best_idx_chain[ENTRIES];
    assign lookup_hit = (cmd_reg == CMD_LOOKUP) && scan_chain[ENTRIES].hit;

    assign cnt_wide = CW'(cnt_reg);
    assign cnt_sat  = (cnt_wide > CW'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                   : cnt_wide[COUNT_W-1:0];

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    state_next = ST_HOLD;
                    // new key landing in a free entry
                    if (wr_en && !scan_chain[ENTRIES].hit && !scan_chain[ENTRIES].best_vld) begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            start_reg   <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            start_reg   <= s_xfer;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            cmd_reg     <= s_tuser[0];
            key_hi_reg  <= s_tdata[KEY_W-1:0];
            key_lo_reg  <= s_tdata[2*KEY_W-1:KEY_W];
            now_reg     <= s_tdata[2*KEY_W+TIME_W-1:2*KEY_W];
            payload_reg <= s_tdata[2*KEY_W+TIME_W+PAYLOAD_BITS-1:2*KEY_W+TIME_W];
        end
        if (scan_done) begin
            res_found_reg <= lookup_hit;
            res_time_reg  <= lookup_hit ? scan_chain[ENTRIES].hit_time : '0;
            res_data_reg  <= lookup_hit ? DATA_W'(hit_data_chain[ENTRIES]) : '0;
        end
        if ((state_reg == ST_HOLD) && out_free) begin
            m_found_reg <= res_found_reg;
            m_time_reg  <= res_time_reg;
            m_data_reg  <= res_data_reg;
            m_count_reg <= cnt_sat;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = M_TUSER_W'(m_found_reg);
    assign m_tdata  = {PAD_W'(0), m_count_reg, m_data_reg, m_time_reg};

endmodule

// File: rtl/kto_checker.sv
// Port-level checks for the keyed table, bound to the top level.
`timescale 1ns / 1ps
module kto_checker #(
    parameter int ENTRIES = 24
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [kto_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [kto_pkg::M_TUSER_W-1:0] m_tuser
);
    import kto_pkg::*;

    localparam int CNT_LSB = TIME_W + DATA_W;

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one command in flight: input closes after each transfer
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input reopened during search");

    // a miss or record reports zero time and payload
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[CNT_LSB-1:0] == '0)
        else $error("non-zero data without a hit");

    // count never exceeds the table size
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (int'(m_tdata[CNT_LSB+COUNT_W-1:CNT_LSB]) <= ENTRIES))
        else $error("used count beyond table size");

endmodule

bind keyed_table_oldest_replace kto_checker #(
    .ENTRIES(ENTRIES)
) u_kto_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);
